// ----- hdl/ceq_pkg.sv -----
`default_nettype none

package ceq_pkg;

  // Field widths of the stream items
  localparam int unsigned ID_W   = 4;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned FLAG_N = 1 << ID_W;

  // Item kinds on the input side
  typedef enum logic {
    ACT_SIGNAL = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_REFUSED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/ceq_ram.sv -----
`default_nettype none

module ceq_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port (read returns old data)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/coalescing_event_queue.sv -----
`default_nettype none

// Channel  Dir  tdata                                   tuser
// s_*      in   [3:0] event_id, [7:4] zero              [0] action (0 signal, 1 pop)
// m_*      out  [3:0] popped_id, [8:4] occupancy, rest 0 [1:0] status
//
// One item per cycle sustained while the output is not stalled (input register,
// then one pass of flag test and ring update, then the result register).
// The ring sits in a RAM with registered read; its read port always points at
// the next head, with a registered bypass when a write lands on that entry.
// Synchronous active-high reset clears flags, pointers, count and valids.
// A stalled output holds its result; the input stage keeps one item waiting.

module coalescing_event_queue #(
  parameter int unsigned EVENT_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [3:0] event_id
  input  wire logic [0:0]  s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [3:0] popped_id, [8:4] occupancy
  output logic      [1:0]  m_tuser    // [1:0] status
);

  import ceq_pkg::*;

  localparam int unsigned AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int unsigned CW = $clog2(EVENT_SLOTS + 1);

  // input register
  logic            in_valid;
  action_t         in_action;
  logic [ID_W-1:0] in_id;

  // queue state
  logic [FLAG_N-1:0] pending, pending_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CW-1:0]     count, count_next;

  // ring read bypass
  logic            byp_valid;
  logic [ID_W-1:0] byp_data;

  // result register
  logic             out_valid;
  status_t          out_status;
  logic [ID_W-1:0]  out_popped;
  logic [OCC_W-1:0] out_occ;

  logic            proc;
  logic            wr_en;
  logic [ID_W-1:0] ram_rdata;
  logic [ID_W-1:0] head_id;
  logic            id_ok;
  status_t         status;
  logic [ID_W-1:0] popped;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    if (p == AW'(EVENT_SLOTS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign proc     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || proc;
  assign head_id  = byp_valid ? byp_data : ram_rdata;
  assign id_ok    = 32'(in_id) < EVENT_SLOTS;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_action <= action_t'(s_tuser[0]);
      in_id     <= s_tdata[ID_W-1:0];
    end
  end

  // flag test, ring access and pointer update for one item
  always_comb begin
    pending_next = pending;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    wr_en        = 1'b0;
    status       = ST_REFUSED;
    popped       = '0;
    if (proc) begin
      unique case (in_action)
        ACT_SIGNAL: begin
          if (!id_ok || pending[in_id] || count >= CW'(EVENT_SLOTS)) begin
            status = ST_REFUSED;
          end else begin
            pending_next[in_id] = 1'b1;
            wr_en               = 1'b1;
            tail_next           = adv(tail);
            count_next          = count + 1'b1;
            status              = ST_QUEUED;
          end
        end
        ACT_POP: begin
          if (count == '0) begin
            status = ST_EMPTY;
          end else begin
            popped                = head_id;
            pending_next[head_id] = 1'b0;
            head_next             = adv(head);
            count_next            = count - 1'b1;
            status                = ST_POPPED;
          end
        end
        default: status = ST_REFUSED;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      byp_valid <= 1'b0;
    end else begin
      pending   <= pending_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      byp_valid <= wr_en && (tail == head_next);
    end
    byp_data <= in_id;
  end

  // ring storage, read port tracks the next head
  ceq_ram #(
    .WIDTH(ID_W),
    .DEPTH(EVENT_SLOTS)
  ) u_ring (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail),
    .wdata(in_id),
    .raddr(head_next),
    .rdata(ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (proc) begin
      out_status <= status;
      out_popped <= popped;
      out_occ    <= OCC_W'(count_next);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(16 - ID_W - OCC_W){1'b0}}, out_occ, out_popped};

  // occupancy always matches the number of pending flags
  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(pending))
    else $error("count does not match pending flags");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= EVENT_SLOTS)
    else $error("count above slot count");

  a_pop_flag: assert property (@(posedge clk) disable iff (rst)
    proc && status == ST_POPPED |=> !pending[$past(popped)])
    else $error("popped event still pending");

  a_queue_flag: assert property (@(posedge clk) disable iff (rst)
    proc && status == ST_QUEUED |=> pending[$past(in_id)] && count == $past(count) + 1'b1)
    else $error("queued event not recorded");

  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    proc && status == ST_EMPTY |=> head == $past(head) && tail == $past(tail))
    else $error("empty pop moved pointers");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ceq_pkg::*;

  // One input item and one result item as the block sees them
  typedef struct packed {
    action_t         action;
    logic [ID_W-1:0] event_id;
  } event_item_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  popped_id;
    logic [OCC_W-1:0] occupancy;
  } event_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [3:0] event_id
  logic [0:0]  s_tuser = '0;    // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [3:0] popped_id, [8:4] occupancy
  logic [1:0]  m_tuser;         // [1:0] status

  coalescing_event_queue #(.EVENT_SLOTS(FLAG_N)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be sent and results waiting to arrive
  event_item_t   outgoing_events[$];
  event_result_t expected_results[$];

  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 66;
  logic        rx_hold = 1'b0;
  logic        item_taken = 1'b0;
  int unsigned error_count = 0;

  // Shadow copy of the queue state
  logic             shadow_pending [FLAG_N];
  logic [ID_W-1:0]  shadow_ring [FLAG_N];
  logic [ID_W-1:0]  shadow_head = '0;
  logic [ID_W-1:0]  shadow_tail = '0;
  logic [OCC_W-1:0] shadow_count = '0;

  initial begin
    for (int i = 0; i < FLAG_N; i++) begin
      shadow_pending[i] = 1'b0;
      shadow_ring[i] = '0;
    end
  end

  // Apply one item to the shadow state and return the result it causes
  function automatic event_result_t apply_event_item(event_item_t it);
    event_result_t r;
    r.popped_id = '0;
    if (it.action == ACT_SIGNAL) begin
      if (shadow_pending[it.event_id] || shadow_count >= FLAG_N) begin
        r.status = ST_REFUSED;
      end else begin
        shadow_pending[it.event_id] = 1'b1;
        shadow_ring[shadow_tail] = it.event_id;
        shadow_tail = shadow_tail + 1'b1;
        shadow_count = shadow_count + 1'b1;
        r.status = ST_QUEUED;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped_id = shadow_ring[shadow_head];
      shadow_pending[r.popped_id] = 1'b0;
      shadow_head = shadow_head + 1'b1;
      shadow_count = shadow_count - 1'b1;
      r.status = ST_POPPED;
    end
    r.occupancy = shadow_count;
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Input transfers: predict the result of each accepted item
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(apply_event_item(outgoing_events.pop_front()));
      item_taken = 1'b1;
    end
  end

  // Sender: hold an unaccepted item, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
      s_tvalid <= 1'b1;
    end else if (outgoing_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      s_tvalid <= 1'b1;
      s_tdata  <= {4'b0, outgoing_events[0].event_id};
      s_tuser  <= outgoing_events[0].action;
    end else begin
      s_tvalid <= 1'b0;
    end
    item_taken = 1'b0;
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result transfers: compare against the oldest prediction
  always @(posedge clk) begin
    event_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d id=%0d occ=%0d",
                                m_tuser, m_tdata[3:0], m_tdata[8:4]));
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[3:0] !== want.popped_id)
          note_mismatch($sformatf("popped_id %0d, want %0d", m_tdata[3:0], want.popped_id));
        if (m_tdata[8:4] !== want.occupancy)
          note_mismatch($sformatf("occupancy %0d, want %0d", m_tdata[8:4], want.occupancy));
      end
    end
  end

  task automatic queue_event(input action_t act, input logic [ID_W-1:0] id);
    event_item_t it;
    it.action = act;
    it.event_id = id;
    outgoing_events.push_back(it);
  endtask

  // Bursts with a varying signal/pop mix so the queue swings between empty and full
  task automatic queue_random_events(input int unsigned n);
    int unsigned signal_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(3))
          0: signal_pct = 25;
          1: signal_pct = 50;
          2: signal_pct = 75;
          default: signal_pct = 90;
        endcase
      end
      if ($urandom_range(99) < signal_pct)
        queue_event(ACT_SIGNAL, ID_W'($urandom_range(FLAG_N - 1)));
      else
        queue_event(ACT_POP, ID_W'($urandom_range(FLAG_N - 1)));
    end
  endtask

  // Sender pauses here until every transfer is accepted and answered
  task automatic wait_drained();
    while (outgoing_events.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: pop on empty, repeated signal, ordering, then a full queue
    queue_event(ACT_POP, 4'hF);
    queue_event(ACT_SIGNAL, 4'h0);
    queue_event(ACT_SIGNAL, 4'h0);
    queue_event(ACT_SIGNAL, 4'hF);
    queue_event(ACT_POP, 4'hF);
    queue_event(ACT_POP, 4'h0);
    queue_event(ACT_POP, 4'h5);
    for (int i = 0; i < FLAG_N; i++)
      queue_event(ACT_SIGNAL, ID_W'(i));
    // every event pending at once: any further signal is refused
    queue_event(ACT_SIGNAL, 4'h5);
    wait_drained();

    queue_random_events(180);
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 31;
    queue_random_events(180);
    wait_drained();

    // No idling; a long receiver stall first so the input side backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        @(posedge clk) rx_hold = 1'b1;
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    queue_random_events(190);
    wait_drained();

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ceq_pkg.sv
hdl/ceq_ram.sv
hdl/coalescing_event_queue.sv
verif/tb_top.sv
